// ----- design/tilt_kalman_estimator_unit_defines.svh -----
// Assertion macros for the tilt Kalman estimator.
// Included by the top level; no other dependencies.
`ifndef TILT_KALMAN_ESTIMATOR_UNIT_DEFINES_SVH
`define TILT_KALMAN_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TKE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tke_pkg.sv -----
// Shared types, constants and the step program of the tilt Kalman estimator.
// No dependencies.
`default_nettype none
package tke_pkg;

    localparam int CFG_W     = 39;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 25;
    localparam int STEP_W    = 6;
    localparam int NUM_STEPS = 36;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_AA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_AR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_RR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_R    = 3'd4;

    localparam logic [DT_W-1:0]  RST_DT  = 25'd167772;
    localparam logic [CFG_W-1:0] RST_QAA = 39'd4;
    localparam logic [CFG_W-1:0] RST_QAR = 39'd839;
    localparam logic [CFG_W-1:0] RST_QRR = 39'd167772;
    localparam logic [CFG_W-1:0] RST_R   = 39'd167772;

    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    typedef enum logic [4:0] {
        R_PA, R_PR, R_RA, R_RR, R_C00, R_C01, R_C11,
        R_DT, R_Q00, R_Q01, R_Q11, R_RN,
        R_GP, R_GR, R_AP, R_AR,
        R_T, R_A, R_P00, R_P01, R_P11, R_S, R_K0, R_K1, R_YP, R_YR
    } reg_id_t;

    typedef struct packed {
        op_t     op;
        reg_id_t dst;
        reg_id_t a;
        reg_id_t b;
    } instr_t;

    typedef struct packed {
        logic   go;
        logic   load_in;
        logic   load_out;
        instr_t instr;
    } tke_cmd_t;

    typedef struct packed {
        logic done;
    } tke_status_t;

    function automatic instr_t prog(input logic [STEP_W-1:0] i);
        instr_t r;
        r = '{OP_ADD, R_T, R_T, R_T};
        case (i)
            6'd0:  r = '{OP_MUL, R_T,   R_DT,  R_PR};
            6'd1:  r = '{OP_ADD, R_PA,  R_PA,  R_T};
            6'd2:  r = '{OP_MUL, R_T,   R_DT,  R_GP};
            6'd3:  r = '{OP_ADD, R_PR,  R_PR,  R_T};
            6'd4:  r = '{OP_MUL, R_T,   R_DT,  R_RR};
            6'd5:  r = '{OP_ADD, R_RA,  R_RA,  R_T};
            6'd6:  r = '{OP_MUL, R_T,   R_DT,  R_GR};
            6'd7:  r = '{OP_ADD, R_RR,  R_RR,  R_T};
            6'd8:  r = '{OP_MUL, R_T,   R_DT,  R_C11};
            6'd9:  r = '{OP_ADD, R_A,   R_C01, R_T};
            6'd10: r = '{OP_MUL, R_T,   R_DT,  R_C01};
            6'd11: r = '{OP_ADD, R_P00, R_C00, R_T};
            6'd12: r = '{OP_MUL, R_T,   R_DT,  R_A};
            6'd13: r = '{OP_ADD, R_P00, R_P00, R_T};
            6'd14: r = '{OP_ADD, R_P00, R_P00, R_Q00};
            6'd15: r = '{OP_ADD, R_P01, R_A,   R_Q01};
            6'd16: r = '{OP_ADD, R_P11, R_C11, R_Q11};
            6'd17: r = '{OP_ADD, R_S,   R_P00, R_RN};
            6'd18: r = '{OP_DIV, R_K0,  R_P00, R_S};
            6'd19: r = '{OP_DIV, R_K1,  R_P01, R_S};
            6'd20: r = '{OP_SUB, R_YP,  R_AP,  R_PA};
            6'd21: r = '{OP_SUB, R_YR,  R_AR,  R_RA};
            6'd22: r = '{OP_MUL, R_T,   R_K0,  R_YP};
            6'd23: r = '{OP_ADD, R_PA,  R_PA,  R_T};
            6'd24: r = '{OP_MUL, R_T,   R_K1,  R_YP};
            6'd25: r = '{OP_ADD, R_PR,  R_PR,  R_T};
            6'd26: r = '{OP_MUL, R_T,   R_K0,  R_YR};
            6'd27: r = '{OP_ADD, R_RA,  R_RA,  R_T};
            6'd28: r = '{OP_MUL, R_T,   R_K1,  R_YR};
            6'd29: r = '{OP_ADD, R_RR,  R_RR,  R_T};
            6'd30: r = '{OP_MUL, R_T,   R_K0,  R_P00};
            6'd31: r = '{OP_SUB, R_C00, R_P00, R_T};
            6'd32: r = '{OP_MUL, R_T,   R_K0,  R_P01};
            6'd33: r = '{OP_SUB, R_C01, R_P01, R_T};
            6'd34: r = '{OP_MUL, R_T,   R_K1,  R_P01};
            6'd35: r = '{OP_SUB, R_C11, R_P11, R_T};
            default: r = '{OP_ADD, R_T, R_T, R_T};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/tke_controller.sv -----
// Step sequencer of the tilt Kalman estimator: input/output handshakes, program counter.
// Depends on tke_pkg.
`default_nettype none
module tke_controller
    import tke_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output tke_cmd_t         cmd,
    input  wire tke_status_t status
);
    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_FIN} state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                mvalid_reg, mvalid_next;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        mvalid_next = mvalid_reg;
        cmd.go       = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.load_out = 1'b0;
        cmd.instr    = prog(step_reg);
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    step_next   = '0;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE: begin
                cmd.go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (status.done) begin
                    if (step_reg == STEP_W'(NUM_STEPS - 1)) begin
                        state_next = S_FIN;
                    end else begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_FIN: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
endmodule
`default_nettype wire

// ----- design/tke_datapath.sv -----
// Datapath of the tilt Kalman estimator: state and scratch registers, config
// registers, saturating adder, 8-bit-digit multiplier, restoring divider. Depends on tke_pkg.
`default_nettype none
module tke_datapath
    import tke_pkg::*;
#(
    parameter int VW = 40,
    parameter int FB = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic [VW-1:0]        in_gp,
    input  wire logic [VW-1:0]        in_gr,
    input  wire logic [VW-1:0]        in_ap,
    input  wire logic [VW-1:0]        in_ar,
    input  wire tke_cmd_t             cmd,
    output tke_status_t               status,
    output logic [VW-1:0]             pitch_out,
    output logic [VW-1:0]             roll_out,
    output logic                      fault_out
);
    localparam int MW = 2 * VW;
    localparam int ND = (VW + 7) / 8;
    localparam int BW = ND * 8;
    localparam int NW = VW + FB;
    localparam int CW = $clog2(NW + 1);
    localparam logic [63:0]   MAXP  = (64'd1 << (VW - 1)) - 64'd1;
    localparam logic [63:0]   ONEP  = 64'd1 << FB;
    localparam logic [VW-1:0] MAXV  = VW'(MAXP);
    localparam logic [VW-1:0] MINV  = ~MAXV;
    localparam logic [VW-1:0] ONEV  = (ONEP > MAXP) ? VW'(MAXP) : VW'(ONEP);
    localparam logic [MW-1:0] LIMP  = MW'(MAXP);
    localparam logic [MW-1:0] HALF  = MW'(1) << (FB - 1);

    logic [DT_W-1:0]  dt_reg;
    logic [CFG_W-1:0] qaa_reg, qar_reg, qrr_reg, rn_reg;
    logic [VW-1:0] pa_reg, pr_reg, ra_reg, rr_reg, c00_reg, c01_reg, c11_reg;
    logic [VW-1:0] gp_reg, gr_reg, ap_reg, ar_reg;
    logic [VW-1:0] t_reg, a_tmp_reg, p00_reg, p01_reg, p11_reg, s_reg;
    logic [VW-1:0] k0_reg, k1_reg, yp_reg, yr_reg;
    logic [VW-1:0] pitch_reg, roll_reg;
    logic          fault_reg, fault_o_reg;

    op_t           op_reg;
    reg_id_t       dst_reg;
    logic          busy_reg, done_reg, neg_reg, zero_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] a_reg, b_reg, ma_reg, dm_reg, rem_reg;
    logic [BW-1:0] mb_reg;
    logic [MW-1:0] acc_reg;
    logic [NW-1:0] num_reg, quo_reg;

    logic [VW-1:0] opa, opb, wr_val;
    logic          wr_en;
    logic [VW+7:0] pp;
    logic [MW-1:0] rnd, mq;
    logic [VW:0]   rs, diff;
    logic          ge;

    function automatic logic [VW-1:0] clipc(input logic [CFG_W-1:0] v);
        return (64'(v) > MAXP) ? MAXV : VW'(v);
    endfunction

    function automatic logic [VW-1:0] mag(input logic [VW-1:0] x);
        return x[VW-1] ? (~x + VW'(1)) : x;
    endfunction

    function automatic logic [VW-1:0] sat_as(input logic [VW-1:0] a, input logic [VW-1:0] b,
                                             input logic sub);
        logic [VW:0] s;
        s = sub ? ({a[VW-1], a} - {b[VW-1], b}) : ({a[VW-1], a} + {b[VW-1], b});
        if (s[VW] != s[VW-1]) begin
            return s[VW] ? MINV : MAXV;
        end
        return s[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] pack(input logic neg, input logic [MW-1:0] q);
        logic [MW-1:0] nq;
        nq = ~q + MW'(1);
        if (neg) begin
            return (q > LIMP + MW'(1)) ? MINV : nq[VW-1:0];
        end
        return (q > LIMP) ? MAXV : q[VW-1:0];
    endfunction

    function automatic logic [VW-1:0] rd(input reg_id_t id);
        logic [VW-1:0] v;
        case (id)
            R_PA:    v = pa_reg;
            R_PR:    v = pr_reg;
            R_RA:    v = ra_reg;
            R_RR:    v = rr_reg;
            R_C00:   v = c00_reg;
            R_C01:   v = c01_reg;
            R_C11:   v = c11_reg;
            R_DT:    v = clipc(CFG_W'(dt_reg));
            R_Q00:   v = clipc(qaa_reg);
            R_Q01:   v = clipc(qar_reg);
            R_Q11:   v = clipc(qrr_reg);
            R_RN:    v = clipc(rn_reg);
            R_GP:    v = gp_reg;
            R_GR:    v = gr_reg;
            R_AP:    v = ap_reg;
            R_AR:    v = ar_reg;
            R_T:     v = t_reg;
            R_A:     v = a_tmp_reg;
            R_P00:   v = p00_reg;
            R_P01:   v = p01_reg;
            R_P11:   v = p11_reg;
            R_S:     v = s_reg;
            R_K0:    v = k0_reg;
            R_K1:    v = k1_reg;
            R_YP:    v = yp_reg;
            R_YR:    v = yr_reg;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        opa  = rd(cmd.instr.a);
        opb  = rd(cmd.instr.b);
        pp   = ma_reg * mb_reg[BW-1 -: 8];
        rnd  = acc_reg + HALF;
        mq   = rnd >> FB;
        rs   = {rem_reg, num_reg[NW-1]};
        diff = rs - {1'b0, dm_reg};
        ge   = (rs >= {1'b0, dm_reg});
        wr_en = busy_reg && (cnt_reg == '0);
        case (op_reg)
            OP_ADD:  wr_val = sat_as(a_reg, b_reg, 1'b0);
            OP_SUB:  wr_val = sat_as(a_reg, b_reg, 1'b1);
            OP_MUL:  wr_val = pack(neg_reg, mq);
            OP_DIV:  wr_val = zero_reg ? '0 : pack(neg_reg, MW'(quo_reg));
            default: wr_val = '0;
        endcase
    end

    // sequencing of the shared units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.go) begin
                busy_reg <= 1'b1;
                case (cmd.instr.op)
                    OP_MUL:  cnt_reg <= CW'(ND);
                    OP_DIV:  cnt_reg <= (opb[VW-1] || opb == '0) ? '0 : CW'(NW);
                    default: cnt_reg <= '0;
                endcase
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.go) begin
            op_reg   <= cmd.instr.op;
            dst_reg  <= cmd.instr.dst;
            a_reg    <= opa;
            b_reg    <= opb;
            ma_reg   <= mag(opa);
            mb_reg   <= BW'(mag(opb));
            neg_reg  <= (cmd.instr.op == OP_DIV) ? opa[VW-1] : (opa[VW-1] ^ opb[VW-1]);
            zero_reg <= opb[VW-1] || (opb == '0);
            acc_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            num_reg  <= NW'(mag(opa)) << FB;
            dm_reg   <= opb;
        end else if (busy_reg && cnt_reg != '0) begin
            acc_reg <= (acc_reg << 8) + MW'(pp);
            mb_reg  <= mb_reg << 8;
            rem_reg <= ge ? diff[VW-1:0] : rs[VW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
            num_reg <= num_reg << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_reg  <= RST_DT;
            qaa_reg <= RST_QAA;
            qar_reg <= RST_QAR;
            qrr_reg <= RST_QRR;
            rn_reg  <= RST_R;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TIME_STEP: dt_reg  <= cfg_wdata[DT_W-1:0];
                CFG_NOISE_AA:  qaa_reg <= cfg_wdata;
                CFG_NOISE_AR:  qar_reg <= cfg_wdata;
                CFG_NOISE_RR:  qrr_reg <= cfg_wdata;
                CFG_MEAS_R:    rn_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_reg    <= '0;
            pr_reg    <= '0;
            ra_reg    <= '0;
            rr_reg    <= '0;
            c00_reg   <= ONEV;
            c01_reg   <= '0;
            c11_reg   <= ONEV;
            fault_reg <= 1'b0;
        end else begin
            if (cmd.go && cmd.instr.op == OP_DIV) begin
                fault_reg <= opb[VW-1] || (opb == '0);
            end
            if (wr_en) begin
                case (dst_reg)
                    R_PA:  pa_reg  <= wr_val;
                    R_PR:  pr_reg  <= wr_val;
                    R_RA:  ra_reg  <= wr_val;
                    R_RR:  rr_reg  <= wr_val;
                    R_C00: c00_reg <= wr_val;
                    R_C01: c01_reg <= wr_val;
                    R_C11: c11_reg <= wr_val;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            gp_reg <= in_gp;
            gr_reg <= in_gr;
            ap_reg <= in_ap;
            ar_reg <= in_ar;
        end
        if (wr_en) begin
            case (dst_reg)
                R_T:   t_reg     <= wr_val;
                R_A:   a_tmp_reg <= wr_val;
                R_P00: p00_reg   <= wr_val;
                R_P01: p01_reg   <= wr_val;
                R_P11: p11_reg   <= wr_val;
                R_S:   s_reg     <= wr_val;
                R_K0:  k0_reg    <= wr_val;
                R_K1:  k1_reg    <= wr_val;
                R_YP:  yp_reg    <= wr_val;
                R_YR:  yr_reg    <= wr_val;
                default: ;
            endcase
        end
        if (cmd.load_out) begin
            pitch_reg   <= pa_reg;
            roll_reg    <= ra_reg;
            fault_o_reg <= fault_reg;
        end
    end

    assign status.done = done_reg;
    assign pitch_out   = pitch_reg;
    assign roll_out    = roll_reg;
    assign fault_out   = fault_o_reg;
endmodule
`default_nettype wire

// ----- design/tilt_kalman_estimator_unit.sv -----
// Tilt Kalman estimator for pitch and roll: one sensor sample in, one estimate out.
// Input stream s_*: one transfer per sample (gyro rates and accelerometer angles).
// Output stream m_*: one transfer per sample (corrected pitch, roll, gain fault).
// Configuration: cfg_we/cfg_index/cfg_wdata write dt, Q00, Q01, Q11, R; write when idle.
// The 36 program steps run on one shared adder, one multiplier that takes
// 8 multiplier bits per cycle and one restoring divider that takes one quotient
// bit per cycle. Per sample the program holds add and subtract steps,
// multiplies and 2 divides. One sample is in work at a time.
// A finished result waits in the output register; a new sample is taken while
// it waits, and the block stalls only at the end of that next sample until the
// receiver takes the earlier result.
// Reset (aresetn low, synchronous): state zero, covariance diagonal one,
// registers to their defaults, no result pending.
// Depends on tke_pkg, tke_controller, tke_datapath and the defines header.
`default_nettype none
`include "tilt_kalman_estimator_unit_defines.svh"
module tilt_kalman_estimator_unit
    import tke_pkg::*;
#(
    parameter int VALUE_WIDTH   = 40,
    parameter int FRACTION_BITS = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // gyro_pitch_rate, gyro_roll_rate, accel_pitch_angle, accel_roll_angle
    input  wire logic [((4*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pitch_estimate, roll_estimate, gain_fault
    output logic [((2*VALUE_WIDTH+8)/8)*8-1:0]      m_tdata
);
    localparam int VW  = VALUE_WIDTH;
    localparam int OTW = ((2 * VW + 8) / 8) * 8;

    tke_cmd_t      cmd;
    tke_status_t   status;
    logic [VW-1:0] pitch, roll;
    logic          fault;

    tke_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    tke_datapath #(
        .VW (VW),
        .FB (FRACTION_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_gp     (s_tdata[VW-1:0]),
        .in_gr     (s_tdata[2*VW-1:VW]),
        .in_ap     (s_tdata[3*VW-1:2*VW]),
        .in_ar     (s_tdata[4*VW-1:3*VW]),
        .cmd       (cmd),
        .status    (status),
        .pitch_out (pitch),
        .roll_out  (roll),
        .fault_out (fault)
    );

    assign m_tdata = OTW'({fault, roll, pitch});

    `TKE_ASSERT_NEXT(a_one_in_work, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second sample taken while busy")
    `TKE_ASSERT_NOW(a_go_not_done, aclk, aresetn, cmd.go, !status.done, "step issued while unit reports done")
    `TKE_ASSERT_NOW(a_load_out_free, aclk, aresetn, cmd.load_out, !m_tvalid || m_tready, "result overwritten before transfer")
endmodule
`default_nettype wire

// ----- tb/sv/tb_tilt_kalman_estimator_unit.sv -----
// Testbench for tilt_kalman_estimator_unit: a queue-fed stream driver, a monitor and
// an in-bench fixed-point Kalman predictor checked against every output transfer.
// Depends on tke_pkg and the tilt_kalman_estimator_unit RTL.
`default_nettype none
module tb_tilt_kalman_estimator_unit;
    import tke_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = 40;
    localparam int FB = 24;
    localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;

    typedef struct {
        logic [VW-1:0] gp, gr, ap, ar;
    } sample_t;

    typedef struct {
        logic [VW-1:0] pitch, roll;
        logic          fault;
    } estimate_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [159:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [87:0] m_tdata;

    tilt_kalman_estimator_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    sample_t   sample_q[$];
    estimate_t estimate_q[$];
    int        errors = 0;
    int        cyc = 0;
    bit        rx_hold = 0;

    // filter copy of registers and state
    longint dt_r, qaa_r, qar_r, qrr_r, rn_r;
    longint pa, pr, ra, rr, c00, c01, c11;

    function automatic longint clamp(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint sadd(longint a, longint b);
        return clamp(a + b);
    endfunction

    function automatic longint ssub(longint a, longint b);
        return clamp(a - b);
    endfunction

    function automatic longint fold(bit neg, logic [127:0] m);
        logic [127:0] lim;
        lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
        if (m > lim) return neg ? VMIN : VMAX;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic logic [127:0] magn(longint v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    function automatic longint fmul(longint a, longint b);
        logic [127:0] m;
        m = magn(a) * magn(b);
        m = (m + (128'd1 << (FB - 1))) >> FB;
        return fold((a < 0) != (b < 0), m);
    endfunction

    function automatic longint fdiv(longint n, longint d);
        logic [127:0] q;
        q = (magn(n) << FB) / 128'(d);
        return fold(n < 0, q);
    endfunction

    function automatic longint sx(logic [VW-1:0] v);
        return longint'(signed'(v));
    endfunction

    task automatic filter_reset();
        dt_r = longint'(RST_DT); qaa_r = longint'(RST_QAA); qar_r = longint'(RST_QAR);
        qrr_r = longint'(RST_QRR); rn_r = longint'(RST_R);
        pa = 0; pr = 0; ra = 0; rr = 0;
        c00 = 64'sd1 <<< FB; c01 = 0; c11 = 64'sd1 <<< FB;
    endtask

    task automatic kalman_update(input sample_t s);
        longint a, p00, p01, p11, sv, k0, k1, yp, yr;
        estimate_t e;
        pa = sadd(pa, fmul(dt_r, pr));
        pr = sadd(pr, fmul(dt_r, sx(s.gp)));
        ra = sadd(ra, fmul(dt_r, rr));
        rr = sadd(rr, fmul(dt_r, sx(s.gr)));
        a = sadd(c01, fmul(dt_r, c11));
        p00 = sadd(c00, fmul(dt_r, c01));
        p00 = sadd(sadd(p00, fmul(dt_r, a)), qaa_r);
        p01 = sadd(a, qar_r);
        p11 = sadd(c11, qrr_r);
        sv = sadd(p00, rn_r);
        e.fault = sv <= 0;
        k0 = 0; k1 = 0;
        if (!e.fault) begin
            k0 = fdiv(p00, sv);
            k1 = fdiv(p01, sv);
        end
        yp = ssub(sx(s.ap), pa);
        yr = ssub(sx(s.ar), ra);
        pa = sadd(pa, fmul(k0, yp));
        pr = sadd(pr, fmul(k1, yp));
        ra = sadd(ra, fmul(k0, yr));
        rr = sadd(rr, fmul(k1, yr));
        c00 = ssub(p00, fmul(k0, p00));
        c01 = ssub(p01, fmul(k0, p01));
        c11 = ssub(p11, fmul(k1, p01));
        e.pitch = pa[VW-1:0];
        e.roll = ra[VW-1:0];
        estimate_q.push_back(e);
    endtask

    task automatic report(input string what, input logic [VW-1:0] got, input logic [VW-1:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic bit idle_now();
        if (cyc >= 30000 && cyc < 70000) return 0;
        return $urandom_range(99) < 14;
    endfunction

    always @(posedge aclk) cyc <= cyc + 1;

    // sender
    sample_t cur;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) kalman_update(cur);
            if (sample_q.size() > 0 && !idle_now()) begin
                cur = sample_q.pop_front();
                s_tdata <= {cur.ar, cur.ap, cur.gr, cur.gp};
                s_tvalid <= 1;
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else m_tready <= !rx_hold && !idle_now();
    end

    always @(posedge aclk) begin
        estimate_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (estimate_q.size() == 0) begin
                $display("unexpected output transfer at %0t", $realtime);
                errors++;
            end else begin
                e = estimate_q.pop_front();
                if (m_tdata[39:0] !== e.pitch) report("pitch", m_tdata[39:0], e.pitch);
                if (m_tdata[79:40] !== e.roll) report("roll", m_tdata[79:40], e.roll);
                if (m_tdata[80] !== e.fault) report("fault", {39'd0, m_tdata[80]}, {39'd0, e.fault});
            end
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            CFG_TIME_STEP: dt_r = longint'(val[DT_W-1:0]);
            CFG_NOISE_AA:  qaa_r = longint'(val);
            CFG_NOISE_AR:  qar_r = longint'(val);
            CFG_NOISE_RR:  qrr_r = longint'(val);
            CFG_MEAS_R:    rn_r = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [CFG_W-1:0] dt, input logic [CFG_W-1:0] qaa,
                           input logic [CFG_W-1:0] qar, input logic [CFG_W-1:0] qrr,
                           input logic [CFG_W-1:0] rn);
        reg_write(CFG_TIME_STEP, dt);
        reg_write(CFG_NOISE_AA, qaa);
        reg_write(CFG_NOISE_AR, qar);
        reg_write(CFG_NOISE_RR, qrr);
        reg_write(CFG_MEAS_R, rn);
    endtask

    task automatic drain();
        while (sample_q.size() > 0 || s_tvalid || estimate_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [VW-1:0] rnd_val();
        logic [VW-1:0] v;
        int k;
        k = $urandom_range(9);
        v = VW'({$urandom, $urandom});
        if (k < 6) v = VW'(signed'(VW'(int'($urandom_range(200 << 12)) - (100 << 12)))) << 12;
        else if (k == 6) v = $urandom_range(1) ? VW'(VMAX) : VW'(VMIN);
        return v;
    endfunction

    task automatic push_random(input int n);
        sample_t s;
        repeat (n) begin
            s.gp = rnd_val(); s.gr = rnd_val(); s.ap = rnd_val(); s.ar = rnd_val();
            sample_q.push_back(s);
        end
    endtask

    task automatic push_one(input longint gp, input longint gr, input longint ap,
                            input longint ar);
        sample_t s;
        s.gp = gp[VW-1:0]; s.gr = gr[VW-1:0]; s.ap = ap[VW-1:0]; s.ar = ar[VW-1:0];
        sample_q.push_back(s);
    endtask

    initial begin
        filter_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        push_one(0, 0, 0, 0);
        push_one(VMAX, VMIN, VMAX, VMIN);
        push_one(VMIN, VMAX, VMIN, VMAX);
        push_one(VMAX, VMAX, VMAX, VMAX);
        push_one(VMIN, VMIN, VMIN, VMIN);
        push_one(-1, 1, -1, 1);
        push_one(64'sd45 <<< FB, -(64'sd30 <<< FB), 64'sd10 <<< FB, -(64'sd5 <<< FB));
        push_one(0, 0, 0, 0);
        drain();

        // extremes, out-of-range dt gets masked, unused indexes ignored
        set_all(39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF,
                39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF);
        reg_write(CFG_NONE_LO, 39'h12345);
        reg_write(CFG_NONE_HI, 39'h7F_FFFF_FFFF);
        push_one(VMAX, VMIN, VMIN, VMAX);
        push_random(200);
        drain();

        set_all(39'd16777216, '0, '0, '0, '0);
        push_random(200);
        drain();

        // zero dt, zero noise: innovation variance collapses to zero
        set_all('0, '0, '0, '0, '0);
        push_random(100);
        drain();

        set_all(CFG_W'(RST_DT), RST_QAA, RST_QAR, RST_QRR, RST_R);
        push_random(500);
        fork
            begin
                repeat (1500) @(posedge aclk);
                rx_hold = 1;
                repeat (3000) @(posedge aclk);
                rx_hold = 0;
            end
        join_none
        drain();

        set_all(CFG_W'($urandom_range(400000)), CFG_W'($urandom_range(5000)),
                CFG_W'($urandom_range(5000)), CFG_W'($urandom_range(400000)),
                CFG_W'($urandom_range(400000)));
        push_random(400);
        drain();

        set_all(39'd1, 39'd1, 39'd1, 39'd1, 39'd1);
        push_random(400);
        drain();
        repeat (400) @(posedge aclk);

        if (errors == 0 && estimate_q.size() == 0) begin
            $display("tb_tilt_kalman_estimator_unit OK");
        end else begin
            $display("tb_tilt_kalman_estimator_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_tilt_kalman_estimator_unit NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/tke_pkg.sv
design/tke_controller.sv
design/tke_datapath.sv
design/tilt_kalman_estimator_unit.sv
tb/sv/tb_tilt_kalman_estimator_unit.sv
